>>> rtl/core/lbmpe_pkg.sv
// Shared widths, constants and payload types of the D2Q9 pressure equilibrium pipeline.
package lbmpe_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIRS       = 9;

	localparam int DIR_REST      = 0;
	localparam int DIR_EAST      = 1;
	localparam int DIR_NORTH     = 2;
	localparam int DIR_WEST      = 3;
	localparam int DIR_SOUTH     = 4;
	localparam int DIR_NORTHEAST = 5;
	localparam int DIR_NORTHWEST = 6;
	localparam int DIR_SOUTHWEST = 7;
	localparam int DIR_SOUTHEAST = 8;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int SUM_W  = PROD_W + 1;
	localparam int Q_W    = 3 * DATA_WIDTH;
	localparam int NUM_W  = 3 * DATA_WIDTH + 8;
	localparam int T_W    = NUM_W - 2 * FRAC_BITS;

	localparam int IN_BITS  = 4 * DATA_WIDTH - 1;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = DIRS * DATA_WIDTH;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam int DIV_ODD   = 9;
	localparam int DIV_SHIFT = 2;
	localparam int RND_SCALE = DIV_ODD << DIV_SHIFT;

	localparam longint unsigned MAG_LIMIT = 64'd1 << (DATA_WIDTH - 1);

	localparam int U_W      = $clog2(DIV_ODD * (MAG_LIMIT + 64'd1));
	localparam int RECIP_SH = U_W + 1;
	localparam int RECIP_W  = RECIP_SH - 3;
	localparam int QE_W     = U_W + RECIP_W - RECIP_SH;

	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SH) / DIV_ODD);

	localparam logic signed [NUM_W-1:0] HALF_N =
		NUM_W'(RND_SCALE / 2) <<< (2 * FRAC_BITS);

	localparam logic [T_W-1:0] BIG_T = T_W'(RND_SCALE) * (T_W'(MAG_LIMIT) + T_W'(1));

	localparam logic [QE_W-1:0] NEG_MAG = QE_W'(MAG_LIMIT);
	localparam logic [QE_W-1:0] POS_MAX = QE_W'(MAG_LIMIT - 64'd1);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] pressure;
		logic signed [DATA_WIDTH-1:0] velocity_y;
		logic signed [DATA_WIDTH-1:0] velocity_x;
		logic        [DATA_WIDTH-2:0] density;
	} node_t;

	typedef struct packed {
		logic        [DATA_WIDTH-2:0] density;
		logic signed [DATA_WIDTH-1:0] pressure;
		logic signed [Q_W-1:0]        qxx;
		logic signed [Q_W-1:0]        qyy;
		logic signed [Q_W-1:0]        qxy;
		logic signed [SUM_W-1:0]      gx;
		logic signed [SUM_W-1:0]      gy;
		logic signed [SUM_W-1:0]      ps;
		logic signed [SUM_W-1:0]      pd;
	} moment_t;

	typedef logic signed [NUM_W-1:0]      num_t;
	typedef logic signed [DATA_WIDTH-1:0] pop_t;

endpackage

>>> rtl/core/lbmpe_prod.sv
// Product stages: density and pressure times velocity, then rho*u*u as half-width products, then recombined.
module lbmpe_prod import lbmpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  node_t   in_node,
	output logic    out_valid,
	input  logic    out_ready,
	output moment_t out_mom
);

	logic adv1, adv2, adv3;
	logic valid_s1, valid_s2, valid_s3;

	logic signed [DATA_WIDTH-1:0] rho_ext;
	logic signed [PROD_W-1:0]     rx_c, ry_c, px_c, py_c;

	logic        [DATA_WIDTH-2:0] density_s1;
	logic signed [DATA_WIDTH-1:0] p_s1, vx_s1, vy_s1;
	logic signed [PROD_W-1:0]     rx_s1, ry_s1, px_s1, py_s1;

	logic signed [DATA_WIDTH:0]   rxl, ryl;
	logic signed [DATA_WIDTH-1:0] rxh, ryh;

	logic        [DATA_WIDTH-2:0] density_s2;
	logic signed [DATA_WIDTH-1:0] p_s2;
	logic signed [PROD_W:0]       xxl_s2, yyl_s2, xyl_s2;
	logic signed [PROD_W-1:0]     xxh_s2, yyh_s2, xyh_s2;
	logic signed [SUM_W-1:0]      gx_s2, gy_s2, ps_s2, pd_s2;

	logic        [DATA_WIDTH-2:0] density_s3;
	logic signed [DATA_WIDTH-1:0] p_s3;
	logic signed [Q_W-1:0]        qxx_s3, qyy_s3, qxy_s3;
	logic signed [SUM_W-1:0]      gx_s3, gy_s3, ps_s3, pd_s3;

	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		rho_ext = {1'b0, in_node.density};
		rx_c    = rho_ext * in_node.velocity_x;
		ry_c    = rho_ext * in_node.velocity_y;
		px_c    = in_node.pressure * in_node.velocity_x;
		py_c    = in_node.pressure * in_node.velocity_y;
		rxl     = {1'b0, rx_s1[DATA_WIDTH-1:0]};
		ryl     = {1'b0, ry_s1[DATA_WIDTH-1:0]};
		rxh     = rx_s1[PROD_W-1:DATA_WIDTH];
		ryh     = ry_s1[PROD_W-1:DATA_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			density_s1 <= in_node.density;
			p_s1       <= in_node.pressure;
			vx_s1      <= in_node.velocity_x;
			vy_s1      <= in_node.velocity_y;
			rx_s1      <= rx_c;
			ry_s1      <= ry_c;
			px_s1      <= px_c;
			py_s1      <= py_c;
		end
		if (adv2) begin
			density_s2 <= density_s1;
			p_s2       <= p_s1;
			xxl_s2     <= rxl * vx_s1;
			xxh_s2     <= rxh * vx_s1;
			yyl_s2     <= ryl * vy_s1;
			yyh_s2     <= ryh * vy_s1;
			xyl_s2     <= rxl * vy_s1;
			xyh_s2     <= rxh * vy_s1;
			gx_s2      <= SUM_W'(rx_s1) - SUM_W'(px_s1);
			gy_s2      <= SUM_W'(ry_s1) - SUM_W'(py_s1);
			ps_s2      <= SUM_W'(px_s1) + SUM_W'(py_s1);
			pd_s2      <= SUM_W'(px_s1) - SUM_W'(py_s1);
		end
		if (adv3) begin
			density_s3 <= density_s2;
			p_s3       <= p_s2;
			qxx_s3     <= (Q_W'(xxh_s2) <<< DATA_WIDTH) + Q_W'(xxl_s2);
			qyy_s3     <= (Q_W'(yyh_s2) <<< DATA_WIDTH) + Q_W'(yyl_s2);
			qxy_s3     <= (Q_W'(xyh_s2) <<< DATA_WIDTH) + Q_W'(xyl_s2);
			gx_s3      <= gx_s2;
			gy_s3      <= gy_s2;
			ps_s3      <= ps_s2;
			pd_s3      <= pd_s2;
		end
	end

	assign out_valid = valid_s3;

	always_comb begin
		out_mom.density  = density_s3;
		out_mom.pressure = p_s3;
		out_mom.qxx      = qxx_s3;
		out_mom.qyy      = qyy_s3;
		out_mom.qxy      = qxy_s3;
		out_mom.gx       = gx_s3;
		out_mom.gy       = gy_s3;
		out_mom.ps       = ps_s3;
		out_mom.pd       = pd_s3;
	end

	a_square_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> !qxx_s3[Q_W-1] && !qyy_s3[Q_W-1])
		else $error("rho*u*u recombined to a negative value");

endmodule

>>> rtl/core/lbmpe_sum.sv
// Numerator stages: scaled moment terms, then the nine 36x population numerators.
module lbmpe_sum import lbmpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  moment_t in_mom,
	output logic    out_valid,
	input  logic    out_ready,
	output num_t    num [DIRS]
);

	logic adv4, adv5;
	logic valid_s4, valid_s5;

	num_t r0, p0, qxx, qyy, qxy, gx, gy, ps, pd, sq, spx, spy, sd;
	num_t a_rest_s4, b_rest_s4, a_ax_s4, c_ax_s4, a_ay_s4, c_ay_s4;
	num_t g18x_s4, g18y_s4, d3_s4, pp9_s4, pm9_s4, e9_s4;
	num_t ax, ay;
	num_t num_c [DIRS];
	num_t num_s5 [DIRS];

	assign adv5     = !valid_s5 || out_ready;
	assign adv4     = !valid_s4 || adv5;
	assign in_ready = adv4;

	always_comb begin
		r0  = NUM_W'({1'b0, in_mom.density}) << (2 * FRAC_BITS);
		p0  = NUM_W'($signed(in_mom.pressure)) <<< (2 * FRAC_BITS);
		qxx = NUM_W'($signed(in_mom.qxx));
		qyy = NUM_W'($signed(in_mom.qyy));
		qxy = NUM_W'($signed(in_mom.qxy));
		gx  = NUM_W'($signed(in_mom.gx)) <<< FRAC_BITS;
		gy  = NUM_W'($signed(in_mom.gy)) <<< FRAC_BITS;
		ps  = NUM_W'($signed(in_mom.ps)) <<< FRAC_BITS;
		pd  = NUM_W'($signed(in_mom.pd)) <<< FRAC_BITS;
		sq  = qxx + qyy;
		spx = p0 + qxx;
		spy = p0 + qyy;
		sd  = p0 + sq;

		ax = a_ax_s4 - c_ax_s4;
		ay = a_ay_s4 - c_ay_s4;
		num_c[DIR_REST]      = a_rest_s4 - b_rest_s4;
		num_c[DIR_EAST]      = ax + g18x_s4;
		num_c[DIR_NORTH]     = ay + g18y_s4;
		num_c[DIR_WEST]      = ax - g18x_s4;
		num_c[DIR_SOUTH]     = ay - g18y_s4;
		num_c[DIR_NORTHEAST] = d3_s4 + pp9_s4 + e9_s4;
		num_c[DIR_NORTHWEST] = d3_s4 - pm9_s4 - e9_s4;
		num_c[DIR_SOUTHWEST] = d3_s4 - pp9_s4 + e9_s4;
		num_c[DIR_SOUTHEAST] = d3_s4 + pm9_s4 - e9_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv4) valid_s4 <= in_valid;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			a_rest_s4 <= (r0 <<< 5) + (r0 <<< 2) - (p0 <<< 6) + (p0 <<< 2);
			b_rest_s4 <= (sq <<< 4) + (sq <<< 3);
			a_ax_s4   <= (spx <<< 3) + (spx <<< 2);
			c_ax_s4   <= (qyy <<< 2) + (qyy <<< 1);
			a_ay_s4   <= (spy <<< 3) + (spy <<< 2);
			c_ay_s4   <= (qxx <<< 2) + (qxx <<< 1);
			g18x_s4   <= (gx <<< 4) + (gx <<< 1);
			g18y_s4   <= (gy <<< 4) + (gy <<< 1);
			d3_s4     <= (sd <<< 1) + sd;
			pp9_s4    <= (ps <<< 3) + ps;
			pm9_s4    <= (pd <<< 3) + pd;
			e9_s4     <= (qxy <<< 3) + qxy;
		end
		if (adv5) begin
			for (int i = 0; i < DIRS; i++) begin
				num_s5[i] <= num_c[i];
			end
		end
	end

	assign out_valid = valid_s5;
	assign num       = num_s5;

endmodule

>>> rtl/core/lbmpe_round.sv
// Rounding stages: bias, divide by 36 through a reciprocal product, correct and saturate.
module lbmpe_round import lbmpe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  num_t num [DIRS],
	output logic out_valid,
	input  logic out_ready,
	output pop_t eq [DIRS]
);

	logic adv6, adv7, adv8, adv9;
	logic valid_s6, valid_s7, valid_s8, valid_s9;

	num_t                     biased [DIRS];
	logic [T_W-1:0]           t      [DIRS];
	logic [U_W+RECIP_W-1:0]   prod   [DIRS];
	logic [U_W-1:0]           est9   [DIRS];
	logic [U_W-1:0]           rem    [DIRS];
	logic [QE_W-1:0]          mag    [DIRS];
	pop_t                     sat    [DIRS];

	logic                     neg_s6 [DIRS];
	logic                     big_s6 [DIRS];
	logic [U_W-1:0]           u_s6   [DIRS];
	logic                     neg_s7 [DIRS];
	logic                     big_s7 [DIRS];
	logic [U_W-1:0]           u_s7   [DIRS];
	logic [QE_W-1:0]          qe_s7  [DIRS];
	logic                     neg_s8 [DIRS];
	logic                     big_s8 [DIRS];
	logic [QE_W-1:0]          q_s8   [DIRS];
	pop_t                     eq_s9  [DIRS];

	assign adv9     = !valid_s9 || out_ready;
	assign adv8     = !valid_s8 || adv9;
	assign adv7     = !valid_s7 || adv8;
	assign adv6     = !valid_s6 || adv7;
	assign in_ready = adv6;

	always_comb begin
		for (int i = 0; i < DIRS; i++) begin
			biased[i] = num[i][NUM_W-1] ? (HALF_N - num[i]) : (num[i] + HALF_N);
			t[i]      = biased[i][NUM_W-1:2*FRAC_BITS];
			prod[i]   = (U_W+RECIP_W)'(u_s6[i]) * (U_W+RECIP_W)'(RECIP);
			est9[i]   = U_W'(qe_s7[i]) * U_W'(DIV_ODD);
			rem[i]    = u_s7[i] - est9[i];
			if (neg_s8[i]) begin
				mag[i] = (big_s8[i] || q_s8[i] > NEG_MAG) ? NEG_MAG : q_s8[i];
				sat[i] = DATA_WIDTH'(QE_W'(0) - mag[i]);
			end else begin
				mag[i] = (big_s8[i] || q_s8[i] > POS_MAX) ? POS_MAX : q_s8[i];
				sat[i] = DATA_WIDTH'(mag[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (adv6) valid_s6 <= in_valid;
			if (adv7) valid_s7 <= valid_s6;
			if (adv8) valid_s8 <= valid_s7;
			if (adv9) valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DIRS; i++) begin
			if (adv6) begin
				neg_s6[i] <= num[i][NUM_W-1];
				big_s6[i] <= t[i] >= BIG_T;
				u_s6[i]   <= t[i][U_W+DIV_SHIFT-1:DIV_SHIFT];
			end
			if (adv7) begin
				neg_s7[i] <= neg_s6[i];
				big_s7[i] <= big_s6[i];
				u_s7[i]   <= u_s6[i];
				qe_s7[i]  <= prod[i][U_W+RECIP_W-1:RECIP_SH];
			end
			if (adv8) begin
				neg_s8[i] <= neg_s7[i];
				big_s8[i] <= big_s7[i];
				q_s8[i]   <= qe_s7[i] + QE_W'(rem[i] >= U_W'(DIV_ODD));
			end
			if (adv9) begin
				eq_s9[i] <= sat[i];
			end
		end
	end

	assign out_valid = valid_s9;
	assign eq        = eq_s9;

	for (genvar g = 0; g < DIRS; g++) begin : g_chk
		a_est_low: assert property (@(posedge clk) disable iff (!arst_n)
			valid_s7 |-> est9[g] <= u_s7[g])
			else $error("reciprocal quotient above the true quotient");
		a_est_close: assert property (@(posedge clk) disable iff (!arst_n)
			valid_s7 |-> rem[g] < U_W'(2 * DIV_ODD))
			else $error("reciprocal quotient short by more than one");
		a_sat_sign: assert property (@(posedge clk) disable iff (!arst_n)
			valid_s8 |-> sat[g][DATA_WIDTH-1] == (neg_s8[g] && sat[g] != '0))
			else $error("saturated population has the wrong sign");
	end

endmodule

>>> rtl/core/lbm_d2q9_pressure_equilibrium.sv
// Top level of the D2Q9 pressure-based equilibrium pipeline.
//
// channel   role    handshake                       tdata fields (lowest bit first)
// s_axis    input   s_axis_tvalid / s_axis_tready   density, velocity_x, velocity_y, pressure
// m_axis    output  m_axis_tvalid / m_axis_tready   eq_rest .. eq_southeast, 32 bits each
//
// One node per cycle sustained while m_axis_tready stays high.
// The pipeline has nine register stages: three of products, two of numerator sums,
// four of bias, reciprocal divide by 36, correction and saturation.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on m_axis holds each occupied stage with no empty stage after it; empty stages
// still fill, so s_axis_tready drops only once all nine stages hold a transaction.
module lbm_d2q9_pressure_equilibrium import lbmpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // density, velocity_x, velocity_y, pressure, pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // eq_rest, eq_east, eq_north, eq_west, eq_south,
	                                         // eq_northeast, eq_northwest, eq_southwest,
	                                         // eq_southeast
);

	node_t   node;
	moment_t mom;
	num_t    num [DIRS];
	pop_t    eq  [DIRS];
	logic    mom_valid, mom_ready;
	logic    num_valid, num_ready;

	assign node = node_t'(s_axis_tdata[IN_BITS-1:0]);

	lbmpe_prod u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_node   (node),
		.out_valid (mom_valid),
		.out_ready (mom_ready),
		.out_mom   (mom)
	);

	lbmpe_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mom_valid),
		.in_ready  (mom_ready),
		.in_mom    (mom),
		.out_valid (num_valid),
		.out_ready (num_ready),
		.num       (num)
	);

	lbmpe_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (num_valid),
		.in_ready  (num_ready),
		.num       (num),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.eq        (eq)
	);

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < DIRS; i++) begin
			m_axis_tdata[i*DATA_WIDTH +: DATA_WIDTH] = eq[i];
		end
	end

endmodule
